// ===== rtl/core/gb_glyph_pkg.sv =====
// Package for the GB2312 text to glyph address block.
// Holds glyph kinds, register indexes, beat widths and font ROM constants.
// No dependencies.
package gb_glyph_pkg;

    typedef enum logic [1:0] {
        KIND_16X16 = 2'd0,
        KIND_8X16  = 2'd1,
        KIND_5X8   = 2'd2
    } glyph_kind_t;

    typedef enum logic [0:0] {
        REG_FONT_MODE   = 1'b0,
        REG_DRAW_STATUS = 1'b1
    } cfg_reg_t;

    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;
    localparam int M_TUSER_W   = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 1;
    localparam int ADDR_W      = 18;

    localparam logic [7:0] HANZI_LEAD_LO  = 8'hb0;
    localparam logic [7:0] HANZI_LEAD_HI  = 8'hf7;
    localparam logic [7:0] SYMBOL_LEAD_LO = 8'ha1;
    localparam logic [7:0] SYMBOL_LEAD_HI = 8'ha3;
    localparam logic [7:0] TRAIL_LO       = 8'ha1;
    localparam logic [7:0] PRINT_LO       = 8'h20;
    localparam logic [7:0] PRINT_HI       = 8'h7e;

    localparam logic [6:0]  ROW_SIZE     = 7'd94;
    localparam logic [12:0] HANZI_OFFSET = 13'd846;

    localparam logic [ADDR_W-1:0] ASCII_8X16_BASE = 18'h3cf80;
    localparam logic [ADDR_W-1:0] ASCII_5X8_BASE  = 18'h3bfc0;

    localparam logic [7:0] ADV_16X16 = 8'd16;
    localparam logic [7:0] ADV_8X16  = 8'd8;
    localparam logic [7:0] ADV_5X8   = 8'd6;

endpackage

// ===== rtl/core/gb2312_text_to_glyph_address.sv =====
// Top level: GB2312 / ASCII text stream to font ROM glyph draw requests.
// Depends on gb_glyph_pkg.
//
// Any result beat of an accepted byte is registered in the output register.
// One byte per cycle; the output register forwards ready (stalls while full).
// Reset (aresetn low, synchronous): no string active, no pending lead,
// page and column 0, both config registers 0, output empty.
module gb2312_text_to_glyph_address (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // text_byte[7:0], string_start[8], page[11:9], start_column[19:12], zero pad
    input  logic [gb_glyph_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // font_address[17:0], glyph_page[20:18], glyph_column[28:21],
    // glyph_status[29], zero pad
    output logic [gb_glyph_pkg::M_TDATA_W-1:0]   m_tdata,
    // glyph_kind[1:0]
    output logic [gb_glyph_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gb_glyph_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gb_glyph_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic       font_mode_reg, font_mode_next;
    logic       draw_status_reg, draw_status_next;
    logic       active_reg, active_next;
    logic       lead_pending_reg, lead_pending_next;
    logic [7:0] lead_byte_reg, lead_byte_next;
    logic [7:0] column_reg, column_next;
    logic [2:0] page_reg, page_next;

    logic                                m_valid_reg, m_valid_next;
    gb_glyph_pkg::glyph_kind_t           kind_reg, kind_next;
    logic [gb_glyph_pkg::ADDR_W-1:0]     addr_reg, addr_next;
    logic [2:0]                          out_page_reg, out_page_next;
    logic [7:0]                          out_column_reg, out_column_next;
    logic                                out_status_reg, out_status_next;

    logic       s_accept;
    logic [7:0] in_byte;
    logic       in_start;
    logic [2:0] in_page;
    logic [7:0] in_column;

    logic       act;
    logic       lp;
    logic [2:0] pg;
    logic [7:0] col;
    logic       emit;
    logic [7:0] adv;
    logic       printable;
    logic       is_lead;

    logic [6:0]  lead_off;
    logic [6:0]  trail_off;
    logic [12:0] row_base;
    logic [12:0] glyph_index;
    logic [6:0]  ascii_off;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;

    assign in_byte   = s_tdata[7:0];
    assign in_start  = s_tdata[8];
    assign in_page   = s_tdata[11:9];
    assign in_column = s_tdata[19:12];

    // config writes
    always_comb begin
        font_mode_next   = font_mode_reg;
        draw_status_next = draw_status_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                gb_glyph_pkg::REG_FONT_MODE:   font_mode_next   = cfg_data[0];
                gb_glyph_pkg::REG_DRAW_STATUS: draw_status_next = cfg_data[0];
                default: ;
            endcase
        end
    end

    // address arithmetic
    always_comb begin
        printable = in_byte inside {[gb_glyph_pkg::PRINT_LO : gb_glyph_pkg::PRINT_HI]};
        is_lead   = (in_byte inside
                        {[gb_glyph_pkg::HANZI_LEAD_LO : gb_glyph_pkg::HANZI_LEAD_HI]})
                 || (in_byte inside
                        {[gb_glyph_pkg::SYMBOL_LEAD_LO : gb_glyph_pkg::SYMBOL_LEAD_HI]});
        trail_off = 7'(in_byte - gb_glyph_pkg::TRAIL_LO);
        ascii_off = 7'(in_byte - gb_glyph_pkg::PRINT_LO);
        if (lead_byte_reg inside
                {[gb_glyph_pkg::HANZI_LEAD_LO : gb_glyph_pkg::HANZI_LEAD_HI]}) begin
            lead_off = 7'(lead_byte_reg - gb_glyph_pkg::HANZI_LEAD_LO);
            row_base = ({6'd0, lead_off} * {6'd0, gb_glyph_pkg::ROW_SIZE})
                     + gb_glyph_pkg::HANZI_OFFSET;
        end else begin
            lead_off = 7'(lead_byte_reg - gb_glyph_pkg::SYMBOL_LEAD_LO);
            row_base = {6'd0, lead_off} * {6'd0, gb_glyph_pkg::ROW_SIZE};
        end
        glyph_index = row_base + {6'd0, trail_off};
    end

    // string state and result select
    always_comb begin
        act = in_start || active_reg;
        lp  = in_start ? 1'b0 : lead_pending_reg;
        pg  = in_start ? in_page : page_reg;
        col = in_start ? in_column : column_reg;

        active_next       = active_reg;
        lead_pending_next = lead_pending_reg;
        lead_byte_next    = lead_byte_reg;
        column_next       = column_reg;
        page_next         = page_reg;

        emit      = 1'b0;
        adv       = gb_glyph_pkg::ADV_8X16;
        kind_next = gb_glyph_pkg::KIND_8X16;
        addr_next = gb_glyph_pkg::ASCII_8X16_BASE + {7'd0, ascii_off, 4'd0};

        if (s_accept && act) begin
            active_next       = 1'b1;
            lead_pending_next = lp;
            page_next         = pg;
            column_next       = col;
            if (in_byte == 8'd0) begin
                active_next       = 1'b0;
                lead_pending_next = 1'b0;
            end else if (font_mode_reg) begin
                lead_pending_next = 1'b0;
                if (printable) begin
                    emit      = 1'b1;
                    adv       = gb_glyph_pkg::ADV_5X8;
                    kind_next = gb_glyph_pkg::KIND_5X8;
                    addr_next = gb_glyph_pkg::ASCII_5X8_BASE + {8'd0, ascii_off, 3'd0};
                end
            end else if (lp) begin
                lead_pending_next = 1'b0;
                if (in_byte >= gb_glyph_pkg::TRAIL_LO) begin
                    emit      = 1'b1;
                    adv       = gb_glyph_pkg::ADV_16X16;
                    kind_next = gb_glyph_pkg::KIND_16X16;
                    addr_next = {glyph_index, 5'd0};
                end else if (printable) begin
                    emit = 1'b1;
                end
            end else if (is_lead) begin
                lead_pending_next = 1'b1;
                lead_byte_next    = in_byte;
            end else if (printable) begin
                emit = 1'b1;
            end
            if (emit) begin
                column_next = col + adv;
            end
        end

        out_page_next   = pg;
        out_column_next = col;
        out_status_next = draw_status_reg;

        if (s_accept) begin
            m_valid_next = emit;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            font_mode_reg    <= 1'b0;
            draw_status_reg  <= 1'b0;
            active_reg       <= 1'b0;
            lead_pending_reg <= 1'b0;
            lead_byte_reg    <= 8'd0;
            column_reg       <= 8'd0;
            page_reg         <= 3'd0;
            m_valid_reg      <= 1'b0;
        end else begin
            font_mode_reg    <= font_mode_next;
            draw_status_reg  <= draw_status_next;
            active_reg       <= active_next;
            lead_pending_reg <= lead_pending_next;
            lead_byte_reg    <= lead_byte_next;
            column_reg       <= column_next;
            page_reg         <= page_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // result beat payload
    always_ff @(posedge aclk) begin
        if (s_accept && emit) begin
            kind_reg       <= kind_next;
            addr_reg       <= addr_next;
            out_page_reg   <= out_page_next;
            out_column_reg <= out_column_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {2'd0, out_status_reg, out_column_reg, out_page_reg, addr_reg};

endmodule
